FILE: rtl/ffpa_pkg.sv
// Shared types and constants of the first-fit pool allocator.
`timescale 1ns / 1ps
package ffpa_pkg;

  localparam int POOL_BYTES   = 1024 * 1024;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_SEGMENTS = 64;

  localparam int SIZE_W = 20;
  localparam int ADDR_W = 21;
  localparam int LEN_W  = 21;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_FIT       = 2'd1;
  localparam logic [1:0] ST_BAD_ADDRESS  = 2'd2;
  localparam logic [1:0] ST_NULL_IGNORED = 2'd3;

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_address;
  } out_item_t;

  typedef enum logic [2:0] {
    CO_NONE,
    CO_START,
    CO_SEARCH,
    CO_SPLIT,
    CO_TAKE,
    CO_FREE,
    CO_FREE_NEXT,
    CO_MERGE_PREV
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic              cmd;
    logic [SIZE_W-1:0] req;
    logic [ADDR_W-1:0] addr;
  } cell_bcast_t;

  typedef struct packed {
    logic             valid;
    logic             free;
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             hit;
  } cell_nb_t;

  typedef struct packed {
    logic [LEN_W-1:0] start;
    logic             free;
    logic             split_ok;
    logic             next_free;
    logic             prev_free;
  } cell_info_t;

endpackage

FILE: rtl/ffpa_cell.sv
// One segment slot of the allocator chain: probe, split, merge and shift.
`timescale 1ns / 1ps
module ffpa_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               first_i,
  input  ffpa_pkg::cell_bcast_t bc_i,
  input  logic               probe_i,
  input  ffpa_pkg::cell_nb_t lo_i,
  input  ffpa_pkg::cell_nb_t hi_i,
  output ffpa_pkg::cell_nb_t nb_o,
  output logic               pass_o,
  output logic               dead_o,
  output ffpa_pkg::cell_info_t info_o
);
  import ffpa_pkg::*;

  localparam logic [LEN_W-1:0] HDR = LEN_W'(HEADER_BYTES);

  logic             valid_q, valid_d;
  logic             free_q, free_d;
  logic [LEN_W-1:0] start_q, start_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             probe_q, probe_d;
  logic             hit_q, hit_d;
  logic             passed_q, passed_d;
  logic             match;
  logic             beyond;
  logic [LEN_W-1:0] req_ext;
  logic [LEN_W:0]   need;

  assign req_ext = {1'b0, bc_i.req};
  assign need    = {2'b00, bc_i.req} + (LEN_W+1)'(HEADER_BYTES) + (LEN_W+1)'(1);
  assign beyond  = !passed_q && !hit_q;

  always_comb begin
    if (bc_i.cmd == CMD_FREE) begin
      match = valid_q && ((start_q + HDR) == bc_i.addr);
    end else begin
      match = valid_q && free_q && (len_q >= req_ext);
    end
  end

  assign pass_o = probe_q && valid_q && !match;
  assign dead_o = probe_q && !valid_q;
  assign nb_o   = '{valid: valid_q, free: free_q, start: start_q, len: len_q, hit: hit_q};

  always_comb begin
    info_o = '0;
    if (hit_q) begin
      info_o.start     = start_q;
      info_o.free      = free_q;
      info_o.split_ok  = ({1'b0, len_q} >= need);
      info_o.next_free = hi_i.valid && hi_i.free;
      info_o.prev_free = lo_i.valid && lo_i.free;
    end
  end

  always_comb begin
    valid_d  = valid_q;
    free_d   = free_q;
    start_d  = start_q;
    len_d    = len_q;
    probe_d  = 1'b0;
    hit_d    = hit_q;
    passed_d = passed_q;
    case (bc_i.op)
      CO_START: begin
        probe_d  = first_i;
        hit_d    = 1'b0;
        passed_d = 1'b0;
      end
      CO_SEARCH: begin
        probe_d = probe_i;
        if (probe_q && match) begin
          hit_d = 1'b1;
        end else if (probe_q) begin
          passed_d = 1'b1;
        end
      end
      CO_SPLIT: begin
        if (hit_q) begin
          len_d  = req_ext;
          free_d = 1'b0;
        end else if (lo_i.hit) begin
          valid_d = 1'b1;
          free_d  = 1'b1;
          start_d = lo_i.start + HDR + req_ext;
          len_d   = lo_i.len - req_ext - HDR;
        end else if (beyond) begin
          valid_d = lo_i.valid;
          free_d  = lo_i.free;
          start_d = lo_i.start;
          len_d   = lo_i.len;
        end
      end
      CO_TAKE: begin
        if (hit_q) free_d = 1'b0;
      end
      CO_FREE: begin
        if (hit_q) free_d = 1'b1;
      end
      CO_FREE_NEXT: begin
        if (hit_q) begin
          free_d = 1'b1;
          len_d  = len_q + HDR + hi_i.len;
        end else if (beyond) begin
          valid_d = hi_i.valid;
          free_d  = hi_i.free;
          start_d = hi_i.start;
          len_d   = hi_i.len;
        end
      end
      CO_MERGE_PREV: begin
        if (hi_i.hit) begin
          len_d = len_q + HDR + hi_i.len;
        end else if (hit_q || beyond) begin
          valid_d = hi_i.valid;
          free_d  = hi_i.free;
          start_d = hi_i.start;
          len_d   = hi_i.len;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= first_i;
      free_q   <= 1'b1;
      start_q  <= '0;
      len_q    <= LEN_W'(POOL_BYTES - HEADER_BYTES);
      probe_q  <= 1'b0;
      hit_q    <= 1'b0;
      passed_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      free_q   <= free_d;
      start_q  <= start_d;
      len_q    <= len_d;
      probe_q  <= probe_d;
      hit_q    <= hit_d;
      passed_q <= passed_d;
    end
  end

endmodule

FILE: rtl/first_fit_pool_allocator_unit.sv
// First-fit pool allocator: segment cell chain and command sequencer.
// Each command is taken when the block is idle and yields one result item.
// A probe token walks the chain one cell per cycle during the search;
// a free that merges with its previous neighbor goes through an extra
// merge state before its result is given.
// No new item is taken while a result waits on the output.
`timescale 1ns / 1ps
module first_fit_pool_allocator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ffpa_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ffpa_pkg::out_item_t  out_item_o
);
  import ffpa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_MERGE
  } state_e;

  state_e            state_q;
  logic              cmd_q;
  logic [SIZE_W-1:0] req_q;
  logic [ADDR_W-1:0] addr_q;
  logic              out_valid_q;
  out_item_t         out_q;

  cell_bcast_t bc;
  cell_nb_t    nb_w [MAX_SEGMENTS];
  cell_info_t  info_w [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] pass_w, dead_w, hit_vec;
  cell_info_t  info_all;
  logic        found, miss, accept;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    cell_nb_t lo, hi;
    logic     probe_in;
    if (k == 0) begin : g_lo0
      assign lo       = '0;
      assign probe_in = 1'b0;
    end else begin : g_lon
      assign lo       = nb_w[k-1];
      assign probe_in = pass_w[k-1];
    end
    if (k == MAX_SEGMENTS - 1) begin : g_hil
      assign hi = '0;
    end else begin : g_hin
      assign hi = nb_w[k+1];
    end
    ffpa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .first_i (k == 0),
      .bc_i    (bc),
      .probe_i (probe_in),
      .lo_i    (lo),
      .hi_i    (hi),
      .nb_o    (nb_w[k]),
      .pass_o  (pass_w[k]),
      .dead_o  (dead_w[k]),
      .info_o  (info_w[k])
    );
    assign hit_vec[k] = nb_w[k].hit;
  end

  always_comb begin
    info_all = '0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      info_all = info_all | info_w[k];
    end
  end

  assign found = |hit_vec;
  assign miss  = (|dead_w) || pass_w[MAX_SEGMENTS-1];

  always_comb begin
    bc.cmd  = cmd_q;
    bc.req  = req_q;
    bc.addr = addr_q;
    bc.op   = CO_NONE;
    case (state_q)
      S_IDLE: begin
        if (accept && !(in_item_i.command == CMD_FREE && in_item_i.free_address == '0)) begin
          bc.op = CO_START;
        end
      end
      S_SEARCH: bc.op = CO_SEARCH;
      S_DECIDE: begin
        if (cmd_q == CMD_ALLOC) begin
          bc.op = (info_all.split_ok && !nb_w[MAX_SEGMENTS-1].valid) ? CO_SPLIT : CO_TAKE;
        end else if (!info_all.free) begin
          bc.op = info_all.next_free ? CO_FREE_NEXT : CO_FREE;
        end
      end
      S_MERGE: bc.op = CO_MERGE_PREV;
      default: bc.op = CO_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_ALLOC;
      req_q       <= '0;
      addr_q      <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q  <= in_item_i.command;
            req_q  <= in_item_i.request_size;
            addr_q <= in_item_i.free_address;
            if (in_item_i.command == CMD_FREE && in_item_i.free_address == '0) begin
              out_q       <= '{status: ST_NULL_IGNORED, granted_address: '0};
              out_valid_q <= 1'b1;
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (found) begin
            state_q <= S_DECIDE;
          end else if (miss) begin
            out_q.status          <= (cmd_q == CMD_ALLOC) ? ST_NO_FIT : ST_BAD_ADDRESS;
            out_q.granted_address <= '0;
            out_valid_q           <= 1'b1;
            state_q               <= S_IDLE;
          end
        end
        S_DECIDE: begin
          if (cmd_q == CMD_ALLOC) begin
            out_q.status          <= ST_OK;
            out_q.granted_address <= ADDR_W'(info_all.start + LEN_W'(HEADER_BYTES));
            out_valid_q           <= 1'b1;
            state_q               <= S_IDLE;
          end else begin
            out_q.granted_address <= '0;
            if (info_all.free) begin
              out_q.status <= ST_BAD_ADDRESS;
              out_valid_q  <= 1'b1;
              state_q      <= S_IDLE;
            end else if (info_all.prev_free) begin
              state_q <= S_MERGE;
            end else begin
              out_q.status <= ST_OK;
              out_valid_q  <= 1'b1;
              state_q      <= S_IDLE;
            end
          end
        end
        S_MERGE: begin
          out_q.status <= ST_OK;
          out_valid_q  <= 1'b1;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec)) else $error("more than one cell hit");
  a_found_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> !(found && miss)) else $error("hit and miss together");
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nb_w[0].valid) else $error("first segment lost");
  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK && state_q == S_IDLE |-> out_q.granted_address == '0)
    else $error("address on failed item");
`endif

endmodule

FILE: test/tb_first_fit_pool_allocator_unit.sv
// Testbench for the first-fit pool allocator: directed table plus random commands.
`timescale 1ns / 1ps
module tb_first_fit_pool_allocator_unit;
  import ffpa_pkg::*;

  localparam int LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;

  first_fit_pool_allocator_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  int unsigned seg_start [MAX_SEGMENTS];
  int unsigned seg_len [MAX_SEGMENTS];
  bit seg_free [MAX_SEGMENTS];
  int unsigned seg_cnt;
  int unsigned live_addr [$];

  out_item_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit is_done = 0;

  typedef struct {
    in_item_t item;
    bit known;
    out_item_t res;
  } row_t;

  function automatic out_item_t predict_command(in_item_t it);
    out_item_t r;
    int unsigned req;
    int unsigned i;
    int k;
    r = '0;
    if (it.command == CMD_ALLOC) begin
      req = {12'd0, it.request_size};
      r.status = ST_NO_FIT;
      for (i = 0; i < seg_cnt; i++) begin
        if (seg_free[i] && seg_len[i] >= req) begin
          if (seg_len[i] >= req + HEADER_BYTES + 1 && seg_cnt < MAX_SEGMENTS) begin
            for (k = seg_cnt; k > i + 1; k--) begin
              seg_start[k] = seg_start[k-1];
              seg_len[k] = seg_len[k-1];
              seg_free[k] = seg_free[k-1];
            end
            seg_cnt++;
            seg_start[i+1] = seg_start[i] + HEADER_BYTES + req;
            seg_len[i+1] = seg_len[i] - req - HEADER_BYTES;
            seg_free[i+1] = 1;
            seg_len[i] = req;
          end
          seg_free[i] = 0;
          r.status = ST_OK;
          r.granted_address = ADDR_W'(seg_start[i] + HEADER_BYTES);
          break;
        end
      end
    end else if (it.free_address == 0) begin
      r.status = ST_NULL_IGNORED;
    end else begin
      for (i = 0; i < seg_cnt; i++)
        if (seg_start[i] + HEADER_BYTES == it.free_address) break;
      if (i >= seg_cnt || seg_free[i]) begin
        r.status = ST_BAD_ADDRESS;
      end else begin
        r.status = ST_OK;
        seg_free[i] = 1;
        if (i + 1 < seg_cnt && seg_free[i+1]) begin
          seg_len[i] += HEADER_BYTES + seg_len[i+1];
          for (k = i + 1; k + 1 < seg_cnt; k++) begin
            seg_start[k] = seg_start[k+1];
            seg_len[k] = seg_len[k+1];
            seg_free[k] = seg_free[k+1];
          end
          seg_cnt--;
        end
        if (i > 0 && seg_free[i-1]) begin
          seg_len[i-1] += HEADER_BYTES + seg_len[i];
          for (k = i; k + 1 < seg_cnt; k++) begin
            seg_start[k] = seg_start[k+1];
            seg_len[k] = seg_len[k+1];
            seg_free[k] = seg_free[k+1];
          end
          seg_cnt--;
        end
      end
    end
    return r;
  endfunction

  task automatic send_command(in_item_t it, bit known, out_item_t res);
    out_item_t p;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = predict_command(it);
    if (p.status == ST_OK && it.command == CMD_ALLOC) live_addr.push_back({11'd0, p.granted_address});
    if (known && p != res) begin
      $display("%0t table row expected %h, predictor %h", $time, res, p);
      errors++;
    end
    pending_results.push_back(p);
    @(negedge clk_i);
  endtask

  function automatic in_item_t make_alloc(int unsigned sz);
    in_item_t it;
    it = '0;
    it.command = CMD_ALLOC;
    it.request_size = SIZE_W'(sz);
    it.free_address = ADDR_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_free(int unsigned a);
    in_item_t it;
    it = '0;
    it.command = CMD_FREE;
    it.request_size = SIZE_W'($urandom);
    it.free_address = ADDR_W'(a);
    return it;
  endfunction

  always @(negedge clk_i)
    out_stall_i <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_item_o);
        errors++;
      end else begin
        if (out_item_o.status != pending_results[0].status ||
            out_item_o.granted_address != pending_results[0].granted_address) begin
          $display("%0t expected %h actual %h", $time, pending_results[0], out_item_o);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
    if (cycles > LIMIT) begin
      $display("** first_fit_pool_allocator_unit: FAILED **");
      $finish;
    end
  end

  task automatic run_random(int n);
    int unsigned sel;
    int unsigned idx;
    int unsigned a;
    out_item_t z;
    z = '0;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        if ($urandom_range(9) == 0) a = $urandom_range(20'hFFFFF);
        else if ($urandom_range(3) == 0) a = $urandom_range(64);
        else a = $urandom_range(40000);
        send_command(make_alloc(a), 0, z);
      end else if (sel < 85 && live_addr.size() > 0) begin
        idx = $urandom_range(live_addr.size() - 1);
        a = live_addr[idx];
        live_addr.delete(idx);
        send_command(make_free(a), 0, z);
      end else if (sel < 90) begin
        send_command(make_free(0), 0, z);
      end else if (sel < 95) begin
        send_command(make_free($urandom_range(21'h1FFFFF)), 0, z);
      end else begin
        send_command(make_free(seg_start[$urandom_range(seg_cnt - 1)] + HEADER_BYTES), 0, z);
      end
    end
  endtask

  row_t rows [$];

  initial begin
    row_t rw;
    int n;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      seg_start[k] = 0; seg_len[k] = 0; seg_free[k] = 0;
    end
    seg_len[0] = POOL_BYTES - HEADER_BYTES;
    seg_free[0] = 1;
    seg_cnt = 1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    rw.known = 1;
    rw.item = make_free(0); rw.res = {ST_NULL_IGNORED, 21'd0}; rows.push_back(rw);
    rw.item = make_free(21'h1FFFFF); rw.res = {ST_BAD_ADDRESS, 21'd0}; rows.push_back(rw);
    rw.item = make_free(HEADER_BYTES); rw.res = {ST_BAD_ADDRESS, 21'd0}; rows.push_back(rw);
    rw.item = make_alloc(20'hFFFFF); rw.res = {ST_NO_FIT, 21'd0}; rows.push_back(rw);
    rw.item = make_alloc(0); rw.res = {ST_OK, 21'(HEADER_BYTES)}; rows.push_back(rw);
    rw.item = make_free(HEADER_BYTES); rw.res = {ST_OK, 21'd0}; rows.push_back(rw);
    rw.item = make_free(HEADER_BYTES); rw.res = {ST_BAD_ADDRESS, 21'd0}; rows.push_back(rw);
    rw.item = make_alloc(POOL_BYTES - HEADER_BYTES);
    rw.res = {ST_OK, 21'(HEADER_BYTES)}; rows.push_back(rw);
    rw.item = make_alloc(0); rw.res = {ST_NO_FIT, 21'd0}; rows.push_back(rw);
    rw.item = make_free(HEADER_BYTES); rw.res = {ST_OK, 21'd0}; rows.push_back(rw);
    rw.known = 0;
    rw.item = make_alloc(100); rows.push_back(rw);
    rw.item = make_alloc(200); rows.push_back(rw);
    rw.item = make_alloc(300); rows.push_back(rw);
    rw.item = make_free(HEADER_BYTES + 124); rows.push_back(rw);
    rw.item = make_free(HEADER_BYTES); rows.push_back(rw);
    rw.item = make_free(HEADER_BYTES + 348); rows.push_back(rw);
    rw.item = make_alloc(POOL_BYTES - 2 * HEADER_BYTES - 1); rows.push_back(rw);
    rw.item = make_alloc(20'hFFFFF); rows.push_back(rw);
    rw.item = make_free(21'h100000); rows.push_back(rw);
    foreach (rows[i]) send_command(rows[i].item, rows[i].known, rows[i].res);

    // fill the table to exercise the no-split case
    for (int k = 0; k < MAX_SEGMENTS + 4; k++) send_command(make_alloc(8), 0, '0);
    while (live_addr.size() > 0) begin
      n = $urandom_range(live_addr.size() - 1);
      send_command(make_free(live_addr[n]), 0, '0);
      live_addr.delete(n);
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 79; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 79; end
        3: begin send_idle = 22; recv_stall = 22; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      run_random(320);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("** first_fit_pool_allocator_unit: PASSED **");
    end else begin
      $display("** first_fit_pool_allocator_unit: FAILED **");
    end
    $finish;
  end
endmodule
